[sv/csat_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csat_pkg
// Shared constants, types and saturation helper for the face SAT test block.
// ----------------------------------------------------------------------------
package csat_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int MAX_PLANES    = 64;
  localparam int FRACTION_BITS = 16;

  localparam int VI_W  = $clog2(MAX_VERTICES);
  localparam int PI_W  = $clog2(MAX_PLANES);
  localparam int VCW   = VI_W + 1;
  localparam int PCW   = PI_W + 1;
  localparam int SH_W  = 64 - FRACTION_BITS;
  localparam int ACC_W = SH_W + 2;

  localparam logic [2:0] F_OWN_V   = 3'd0;
  localparam logic [2:0] F_OTHER_V = 3'd1;
  localparam logic [2:0] F_OWN_P   = 3'd2;
  localparam logic [2:0] F_OTHER_P = 3'd3;
  localparam logic [2:0] F_QUERY   = 3'd4;

  localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] INT_MIN = 32'sh80000000;

  typedef logic signed [ACC_W:0] wide_t;

  typedef struct packed {
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic signed [31:0] off_z;
    logic [VCW-1:0]     own_nv;
    logic [VCW-1:0]     other_nv;
    logic [PCW-1:0]     own_np;
    logic [PCW-1:0]     other_np;
  } query_t;

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > wide_t'(INT_MAX)) return INT_MAX;
    if (v < wide_t'(INT_MIN)) return INT_MIN;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

[sv/csat_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csat_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module csat_ram #(
  parameter int AW = 7,
  parameter int DW = 96
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/csat_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csat_core
// Query sequencer: walks faces and vertices from the stores through one
// shared multiplier, tracks the best face and builds the result.
// ----------------------------------------------------------------------------
module csat_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire csat_pkg::query_t              query,
  output logic                               busy,
  output logic [csat_pkg::PI_W:0]            plane_raddr,
  input  wire logic [127:0]                  plane_rdata,
  output logic [csat_pkg::VI_W:0]            vert_raddr,
  input  wire logic [95:0]                   vert_rdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_collided,
  output logic signed [31:0]                 out_push_x,
  output logic signed [31:0]                 out_push_y,
  output logic signed [31:0]                 out_push_z,
  output logic signed [31:0]                 out_contact_x,
  output logic signed [31:0]                 out_contact_y,
  output logic signed [31:0]                 out_contact_z,
  output logic signed [31:0]                 out_normal_x,
  output logic signed [31:0]                 out_normal_y,
  output logic signed [31:0]                 out_normal_z
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PLOOP = 4'd1;
  localparam logic [3:0] S_PDOT  = 4'd2;
  localparam logic [3:0] S_PFACE = 4'd3;
  localparam logic [3:0] S_VLOOP = 4'd4;
  localparam logic [3:0] S_VDOT  = 4'd5;
  localparam logic [3:0] S_VCMP  = 4'd6;
  localparam logic [3:0] S_FEND  = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_FINAL = 4'd9;

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic [3:0]                    state_r;
  logic [2:0]                    step_r;
  logic                          phase_r;
  logic [csat_pkg::PCW-1:0]      k_r;
  logic [csat_pkg::VCW-1:0]      i_r;
  csat_pkg::query_t              q_r;
  logic                          out_valid_r;
  logic                          best_valid_r;
  logic signed [31:0]            best_depth_r;
  logic signed [31:0]            bnorm_r [3];
  logic signed [31:0]            point_r [3];
  logic signed [31:0]            cp_r [3];
  logic signed [31:0]            corr_r;
  logic signed [csat_pkg::ACC_W-1:0] acc_r;
  logic signed [63:0]            prod_r;

  logic signed [31:0]            o_push_r [3];
  logic signed [31:0]            o_cont_r [3];
  logic signed [31:0]            o_norm_r [3];
  logic                          o_coll_r;

  logic [1:0]                    comp;
  logic signed [31:0]            pl [3];
  logic signed [31:0]            pd;
  logic signed [31:0]            vt [3];
  logic signed [31:0]            off [3];
  logic signed [31:0]            mul_a;
  logic signed [31:0]            mul_b;
  logic signed [csat_pkg::SH_W-1:0] shifted;
  logic signed [csat_pkg::ACC_W-1:0] acc_sum;
  logic [csat_pkg::PCW-1:0]      np;
  logic [csat_pkg::VCW-1:0]      nv;
  logic signed [31:0]            nd;
  logic signed [32:0]            neg_corr;
  logic signed [31:0]            depth;
  logic signed [31:0]            half;
  logic                          facing;

  assign comp = step_r[2:1];
  assign pl[0] = plane_rdata[31:0];
  assign pl[1] = plane_rdata[63:32];
  assign pl[2] = plane_rdata[95:64];
  assign pd    = plane_rdata[127:96];
  assign vt[0] = vert_rdata[31:0];
  assign vt[1] = vert_rdata[63:32];
  assign vt[2] = vert_rdata[95:64];
  assign off[0] = q_r.off_x;
  assign off[1] = q_r.off_y;
  assign off[2] = q_r.off_z;

  assign plane_raddr = {~phase_r, k_r[csat_pkg::PI_W-1:0]};
  assign vert_raddr  = {phase_r, i_r[csat_pkg::VI_W-1:0]};

  assign np = phase_r ? q_r.own_np : q_r.other_np;
  assign nv = phase_r ? q_r.other_nv : q_r.own_nv;

  assign shifted = prod_r[63:csat_pkg::FRACTION_BITS];
  assign acc_sum = ((step_r == 3'd1) ? '0 : acc_r) + csat_pkg::ACC_W'(shifted);
  assign nd = csat_pkg::sat32(csat_pkg::wide_t'(acc_r) + csat_pkg::wide_t'(pd));
  assign neg_corr = -(33'(corr_r));
  assign depth = (corr_r == csat_pkg::INT_MIN) ? csat_pkg::INT_MAX : neg_corr[31:0];
  assign half = best_depth_r >>> 1;
  assign facing = phase_r ? (acc_r > 0) : (acc_r < 0);

  always_comb begin
    mul_a = pl[comp];
    mul_b = off[comp];
    case (state_r)
      S_VDOT: begin
        mul_a = vt[comp];
        mul_b = pl[comp];
      end
      S_UPD: begin
        mul_a = pl[comp];
        mul_b = half;
      end
      S_FINAL: begin
        mul_a = bnorm_r[comp];
        mul_b = best_depth_r;
      end
      default: begin
        mul_a = pl[comp];
        mul_b = off[comp];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      phase_r      <= 1'b0;
      k_r          <= '0;
      i_r          <= '0;
      out_valid_r  <= 1'b0;
      best_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            q_r          <= query;
            phase_r      <= 1'b0;
            k_r          <= '0;
            best_valid_r <= 1'b0;
            state_r      <= S_PLOOP;
          end
        end
        S_PLOOP: begin
          step_r <= '0;
          if (k_r == np) begin
            k_r <= '0;
            if (phase_r) begin
              state_r <= S_FINAL;
            end else begin
              phase_r <= 1'b1;
            end
          end else begin
            state_r <= S_PDOT;
          end
        end
        S_PDOT, S_VDOT: begin
          if (step_r[0]) begin
            acc_r <= acc_sum;
          end
          step_r <= step_r + 3'd1;
          if (step_r == LAST_STEP) begin
            state_r <= (state_r == S_PDOT) ? S_PFACE : S_VCMP;
          end
        end
        S_PFACE: begin
          if (facing) begin
            corr_r  <= csat_pkg::INT_MAX;
            i_r     <= '0;
            state_r <= S_VLOOP;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PLOOP;
          end
        end
        S_VLOOP: begin
          step_r  <= '0;
          state_r <= (i_r == nv) ? S_FEND : S_VDOT;
        end
        S_VCMP: begin
          if (nd < corr_r) begin
            corr_r <= nd;
            cp_r   <= vt;
          end
          i_r     <= i_r + 1'b1;
          state_r <= S_VLOOP;
        end
        S_FEND: begin
          step_r <= '0;
          if (corr_r >= 0) begin
            o_coll_r    <= 1'b0;
            o_push_r    <= '{default: '0};
            o_cont_r    <= '{default: '0};
            o_norm_r    <= '{default: '0};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (best_valid_r && !(depth < best_depth_r)) begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PLOOP;
          end else begin
            best_valid_r <= 1'b1;
            best_depth_r <= depth;
            for (int j = 0; j < 3; j++) begin
              bnorm_r[j] <= phase_r ?
                csat_pkg::sat32(-csat_pkg::wide_t'(pl[j])) : pl[j];
            end
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (step_r[0]) begin
            point_r[comp] <= csat_pkg::sat32(csat_pkg::wide_t'(cp_r[comp]) +
                                             csat_pkg::wide_t'(shifted));
          end
          step_r <= step_r + 3'd1;
          if (step_r == LAST_STEP) begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PLOOP;
          end
        end
        S_FINAL: begin
          if (!best_valid_r) begin
            o_coll_r    <= 1'b1;
            o_push_r    <= '{default: '0};
            o_cont_r    <= '{default: '0};
            o_norm_r    <= '{default: '0};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            if (step_r[0]) begin
              o_push_r[comp] <= csat_pkg::sat32(csat_pkg::wide_t'(shifted));
            end
            step_r <= step_r + 3'd1;
            if (step_r == LAST_STEP) begin
              o_coll_r    <= 1'b1;
              o_cont_r    <= point_r;
              o_norm_r    <= bnorm_r;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_collided  = o_coll_r;
  assign out_push_x    = o_push_r[0];
  assign out_push_y    = o_push_r[1];
  assign out_push_z    = o_push_r[2];
  assign out_contact_x = o_cont_r[0];
  assign out_contact_y = o_cont_r[1];
  assign out_contact_z = o_cont_r[2];
  assign out_normal_x  = o_norm_r[0];
  assign out_normal_y  = o_norm_r[1];
  assign out_normal_z  = o_norm_r[2];

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE && !out_valid_r))
    else $error("query started while busy or result pending");
  a_vdot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VDOT) |-> (i_r < nv))
    else $error("vertex index past count");
  a_upd_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> best_valid_r)
    else $error("best update without valid best");
  a_vcmp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VCMP) |=> (i_r == $past(i_r) + 1'b1))
    else $error("vertex index did not advance");

endmodule
`default_nettype wire

[sv/convex_pair_face_sat_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// convex_pair_face_sat_test
// Face-normal separating-axis test for two convex solids, Q16.16.
//
//   channel  direction  transaction
//   in_      input      vertex/plane load or query (func selects)
//   out_     output     one result per query
//
// Loads are accepted while a result waits, but not while a query runs.
// A query walks the faces of both solids, and for each facing face the
// vertices of the other solid, through the shared multiplier; a separating
// face ends the walk at once.
// A new query waits until the previous result is taken.
// Reset clears control state only; stores are undefined until written.
// ----------------------------------------------------------------------------
module convex_pair_face_sat_test (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_func,
  input  wire logic [5:0]         in_entry_index,
  input  wire logic signed [31:0] in_vx,
  input  wire logic signed [31:0] in_vy,
  input  wire logic signed [31:0] in_vz,
  input  wire logic signed [31:0] in_plane_offset,
  input  wire logic [6:0]         in_own_vertex_count,
  input  wire logic [6:0]         in_other_vertex_count,
  input  wire logic [6:0]         in_own_plane_count,
  input  wire logic [6:0]         in_other_plane_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_collided,
  output logic signed [31:0]      out_push_x,
  output logic signed [31:0]      out_push_y,
  output logic signed [31:0]      out_push_z,
  output logic signed [31:0]      out_contact_x,
  output logic signed [31:0]      out_contact_y,
  output logic signed [31:0]      out_contact_z,
  output logic signed [31:0]      out_normal_x,
  output logic signed [31:0]      out_normal_y,
  output logic signed [31:0]      out_normal_z
);

  logic                       busy;
  logic                       accept;
  logic                       start;
  logic                       vert_we;
  logic                       plane_we;
  logic [csat_pkg::VI_W:0]    vert_waddr;
  logic [csat_pkg::PI_W:0]    plane_waddr;
  logic [csat_pkg::VI_W:0]    vert_raddr;
  logic [csat_pkg::PI_W:0]    plane_raddr;
  logic [95:0]                vert_rdata;
  logic [127:0]               plane_rdata;
  csat_pkg::query_t           query;

  assign in_ready = !busy && ((in_func != csat_pkg::F_QUERY) || !out_valid);
  assign accept   = in_valid && in_ready;
  assign start    = accept && (in_func == csat_pkg::F_QUERY);

  assign vert_we  = accept &&
                    ((in_func == csat_pkg::F_OWN_V) || (in_func == csat_pkg::F_OTHER_V)) &&
                    (32'(in_entry_index) < 32'(csat_pkg::MAX_VERTICES));
  assign plane_we = accept &&
                    ((in_func == csat_pkg::F_OWN_P) || (in_func == csat_pkg::F_OTHER_P)) &&
                    (32'(in_entry_index) < 32'(csat_pkg::MAX_PLANES));
  assign vert_waddr  = {in_func == csat_pkg::F_OTHER_V,
                        csat_pkg::VI_W'(in_entry_index)};
  assign plane_waddr = {in_func == csat_pkg::F_OTHER_P,
                        csat_pkg::PI_W'(in_entry_index)};

  always_comb begin
    query.off_x    = in_vx;
    query.off_y    = in_vy;
    query.off_z    = in_vz;
    query.own_nv   = (32'(in_own_vertex_count) > 32'(csat_pkg::MAX_VERTICES)) ?
                     csat_pkg::VCW'(csat_pkg::MAX_VERTICES) :
                     csat_pkg::VCW'(in_own_vertex_count);
    query.other_nv = (32'(in_other_vertex_count) > 32'(csat_pkg::MAX_VERTICES)) ?
                     csat_pkg::VCW'(csat_pkg::MAX_VERTICES) :
                     csat_pkg::VCW'(in_other_vertex_count);
    query.own_np   = (32'(in_own_plane_count) > 32'(csat_pkg::MAX_PLANES)) ?
                     csat_pkg::PCW'(csat_pkg::MAX_PLANES) :
                     csat_pkg::PCW'(in_own_plane_count);
    query.other_np = (32'(in_other_plane_count) > 32'(csat_pkg::MAX_PLANES)) ?
                     csat_pkg::PCW'(csat_pkg::MAX_PLANES) :
                     csat_pkg::PCW'(in_other_plane_count);
  end

  csat_ram #(.AW(csat_pkg::VI_W + 1), .DW(96)) u_vert_ram (
    .clk     (clk),
    .we      (vert_we),
    .waddr   (vert_waddr),
    .wdata   ({in_vz, in_vy, in_vx}),
    .raddr   (vert_raddr),
    .rdata_r (vert_rdata)
  );

  csat_ram #(.AW(csat_pkg::PI_W + 1), .DW(128)) u_plane_ram (
    .clk     (clk),
    .we      (plane_we),
    .waddr   (plane_waddr),
    .wdata   ({in_plane_offset, in_vz, in_vy, in_vx}),
    .raddr   (plane_raddr),
    .rdata_r (plane_rdata)
  );

  csat_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .query         (query),
    .busy          (busy),
    .plane_raddr   (plane_raddr),
    .plane_rdata   (plane_rdata),
    .vert_raddr    (vert_raddr),
    .vert_rdata    (vert_rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_collided  (out_collided),
    .out_push_x    (out_push_x),
    .out_push_y    (out_push_y),
    .out_push_z    (out_push_z),
    .out_contact_x (out_contact_x),
    .out_contact_y (out_contact_y),
    .out_contact_z (out_contact_z),
    .out_normal_x  (out_normal_x),
    .out_normal_y  (out_normal_y),
    .out_normal_z  (out_normal_z)
  );

endmodule
`default_nettype wire
